FILE: rtl/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants of the look-at view basis unit.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int CoordWidthDef = 32;
  localparam int UnitFrac      = 30;

  localparam logic [1:0] RowX = 2'd0;
  localparam logic [1:0] RowY = 2'd1;
  localparam logic [1:0] RowZ = 2'd2;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] offset;
    logic [1:0]         row;
    logic               last;
    logic               degenerate;
  } out_item_t;

endpackage

FILE: rtl/lav_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_in_if
// Valid/ready channel carrying one eye, target and up vector set.
// ----------------------------------------------------------------------------
interface lav_in_if;
  import lav_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lav_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_out_if
// Valid/ready channel carrying one row of the view basis.
// ----------------------------------------------------------------------------
interface lav_out_if;
  import lav_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lav_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: shift, sum of squares, square root, divide.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int MagWidth  = 33,
  parameter int SideWidth = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [2:0]                         neg_i,
  input  logic [2:0][MagWidth-1:0]           mag_i,
  input  logic [SideWidth-1:0]               side_i,
  output logic                               valid_o,
  output lav_pkg::vec3_t                     unit_o,
  output logic                               zero_o,
  output logic [SideWidth-1:0]               side_o
);
  import lav_pkg::*;

  localparam int NShift = $clog2(MagWidth);
  localparam int NRoot  = 31;
  localparam int NDiv   = 31;
  localparam int Depth  = NShift + 67;

  typedef struct packed {
    logic [2:0]           neg;
    logic                 zero;
    logic [SideWidth-1:0] side;
  } sb_t;

  logic [Depth-1:0]            v_q;
  sb_t                         sb_q [Depth];

  logic [2:0][MagWidth-1:0]    w_q [NShift+1];
  logic [2:0][MagWidth-1:0]    w_d [NShift+1];
  logic [2:0][29:0]            a_q, a_d;
  logic [2:0][59:0]            sq_q, sq_d;

  logic [62:0]                 rt_n_q [NRoot+1];
  logic [62:0]                 rt_n_d [NRoot+1];
  logic [62:0]                 rt_r_q [NRoot+1];
  logic [62:0]                 rt_r_d [NRoot+1];
  logic [2:0][29:0]            rt_a_q [NRoot+1];
  logic [2:0][29:0]            rt_a_d [NRoot+1];

  logic [2:0][60:0]            dv_n_q [NDiv+1];
  logic [2:0][60:0]            dv_n_d [NDiv+1];
  logic [2:0][31:0]            dv_r_q [NDiv+1];
  logic [2:0][31:0]            dv_r_d [NDiv+1];
  logic [2:0][30:0]            dv_q_q [NDiv+1];
  logic [2:0][30:0]            dv_q_d [NDiv+1];
  logic [31:0]                 dv_l_q [NDiv+1];
  logic [31:0]                 dv_l_d [NDiv+1];

  vec3_t                       unit_q, unit_d;
  sb_t                         sb_in;

  always_comb begin
    logic [MagWidth-1:0] orw;
    logic [62:0]         tt;
    logic [32:0]         r2;
    logic [31:0]         len;
    logic [31:0]         qv;

    sb_in = '{neg: neg_i, zero: ~|(mag_i[0] | mag_i[1] | mag_i[2]), side: side_i};

    // Normalize: leading one of the OR word goes to the top bit.
    w_d[0] = mag_i;
    for (int j = 0; j < NShift; j++) begin
      orw      = w_q[j][0] | w_q[j][1] | w_q[j][2];
      w_d[j+1] = w_q[j];
      if ((orw >> (MagWidth - (1 << (NShift - 1 - j)))) == '0) begin
        for (int i = 0; i < 3; i++) begin
          w_d[j+1][i] = w_q[j][i] << (1 << (NShift - 1 - j));
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      a_d[i]  = w_q[NShift][i][MagWidth-1 -: 30];
      sq_d[i] = 60'(a_d[i]) * 60'(a_d[i]);
    end

    rt_n_d[0] = 63'(sq_q[0]) + 63'(sq_q[1]) + 63'(sq_q[2]);
    rt_r_d[0] = '0;
    rt_a_d[0] = a_q;
    for (int j = 0; j < NRoot; j++) begin
      tt          = rt_r_q[j] + (63'(1) << (60 - 2 * j));
      rt_a_d[j+1] = rt_a_q[j];
      if (rt_n_q[j] >= tt) begin
        rt_n_d[j+1] = rt_n_q[j] - tt;
        rt_r_d[j+1] = (rt_r_q[j] >> 1) + (63'(1) << (60 - 2 * j));
      end else begin
        rt_n_d[j+1] = rt_n_q[j];
        rt_r_d[j+1] = rt_r_q[j] >> 1;
      end
    end

    // Divide setup: rounded numerator, top bits preload the remainder.
    len       = rt_r_q[NRoot][31:0];
    dv_l_d[0] = len;
    dv_q_d[0] = '0;
    for (int i = 0; i < 3; i++) begin
      dv_n_d[0][i] = (61'(rt_a_q[NRoot][i]) << UnitFrac) + 61'(len >> 1);
      dv_r_d[0][i] = 32'(dv_n_d[0][i][60:31]);
    end
    for (int j = 0; j < NDiv; j++) begin
      dv_l_d[j+1] = dv_l_q[j];
      dv_n_d[j+1] = dv_n_q[j];
      dv_q_d[j+1] = dv_q_q[j];
      for (int i = 0; i < 3; i++) begin
        r2 = {dv_r_q[j][i], dv_n_q[j][i][30-j]};
        if (r2 >= {1'b0, dv_l_q[j]}) begin
          dv_r_d[j+1][i]       = 32'(r2 - {1'b0, dv_l_q[j]});
          dv_q_d[j+1][i][30-j] = 1'b1;
        end else begin
          dv_r_d[j+1][i] = r2[31:0];
        end
      end
    end

    for (int i = 0; i < 3; i++) begin
      qv = 32'(dv_q_q[NDiv][i]);
      if (sb_q[Depth-2].zero) begin
        unit_d[i] = '0;
      end else if (sb_q[Depth-2].neg[i]) begin
        unit_d[i] = -qv;
      end else begin
        unit_d[i] = qv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_in;
      for (int t = 1; t < Depth; t++) sb_q[t] <= sb_q[t-1];
      for (int t = 0; t <= NShift; t++) w_q[t] <= w_d[t];
      a_q  <= a_d;
      sq_q <= sq_d;
      for (int t = 0; t <= NRoot; t++) begin
        rt_n_q[t] <= rt_n_d[t];
        rt_r_q[t] <= rt_r_d[t];
        rt_a_q[t] <= rt_a_d[t];
      end
      for (int t = 0; t <= NDiv; t++) begin
        dv_n_q[t] <= dv_n_d[t];
        dv_r_q[t] <= dv_r_d[t];
        dv_q_q[t] <= dv_q_d[t];
        dv_l_q[t] <= dv_l_d[t];
      end
      unit_q <= unit_d;
    end
  end

  assign valid_o = v_q[Depth-1];
  assign unit_o  = unit_q;
  assign zero_o  = sb_q[Depth-1].zero;
  assign side_o  = sb_q[Depth-1].side;

endmodule

FILE: rtl/lav_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_out
// Row serializer: holds one finished basis and sends its three rows.
// ----------------------------------------------------------------------------
module lav_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  lav_pkg::vec3_t    xa_i,
  input  lav_pkg::vec3_t    ya_i,
  input  lav_pkg::vec3_t    za_i,
  input  lav_pkg::vec3_t    off_i,
  input  logic              deg_i,
  lav_out_if.source         row_o
);
  import lav_pkg::*;

  logic       busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  vec3_t      xa_q, ya_q, za_q, off_q;
  logic       deg_q;
  logic       load;

  // Take a new basis when empty or while the last row transfers.
  assign ready_o = !busy_q || (row_o.ready && cnt_q == RowZ);
  assign load    = valid_i && ready_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = RowX;
    end else if (busy_q && row_o.ready) begin
      if (cnt_q == RowZ) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= RowX;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      xa_q  <= xa_i;
      ya_q  <= ya_i;
      za_q  <= za_i;
      off_q <= off_i;
      deg_q <= deg_i;
    end
  end

  always_comb begin
    row_o.valid           = busy_q;
    row_o.data.row        = cnt_q;
    row_o.data.last       = (cnt_q == RowZ);
    row_o.data.degenerate = deg_q;
    unique case (cnt_q)
      RowX: begin
        row_o.data.axis_x = xa_q[0];
        row_o.data.axis_y = xa_q[1];
        row_o.data.axis_z = xa_q[2];
        row_o.data.offset = off_q[0];
      end
      RowY: begin
        row_o.data.axis_x = ya_q[0];
        row_o.data.axis_y = ya_q[1];
        row_o.data.axis_z = ya_q[2];
        row_o.data.offset = off_q[1];
      end
      default: begin
        row_o.data.axis_x = za_q[0];
        row_o.data.axis_y = za_q[1];
        row_o.data.axis_z = za_q[2];
        row_o.data.offset = off_q[2];
      end
    endcase
  end

endmodule

FILE: rtl/look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Left-handed look-at view basis in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// item_i transfers one eye/target/up set (signed Q16.16). row_o transfers the
// three basis rows of each set in order x, y, z axis; each row carries unit
// components in Q1.30, the saturated translation -dot(axis, eye) in Q16.16,
// the row number, a last flag on the z row and the degenerate flag.
// An input transfer reaches the first row through two normalizer pipelines
// (shift, square, 31 root steps, 31 divide steps each) plus the cross-product
// and rounding stages. One set enters per cycle while item_i.ready is high,
// but the row port sends three rows per set and so sets the sustained rate.
// The whole pipeline advances on one enable; when the serializer cannot take
// the basis at the end of the tail, every stage holds and item_i.ready drops.
// Reset clears all valid bits and the serializer; data registers keep junk.
// COORD_WIDTH (clamped to 16..32) sets the sign bit of the input coordinates
// and the saturation range of the translation.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit #(
  parameter int COORD_WIDTH = lav_pkg::CoordWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lav_in_if.sink    item_i,
  lav_out_if.source row_o
);
  import lav_pkg::*;

  localparam int Cw     = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int SextSh = 32 - Cw;
  localparam logic [63:0] LimUnit = 64'd1 << UnitFrac;
  localparam logic [63:0] LimPos  = (64'd1 << (Cw - 1)) - 64'd1;
  localparam logic [63:0] LimNeg  = 64'd1 << (Cw - 1);
  localparam int NTail = 10;

  typedef struct packed {
    vec3_t            eye;
    vec3_t            xa;
    vec3_t            ya;
    vec3_t            za;
    vec3_t            off;
    logic             deg;
    logic [11:0][63:0] pr;
    logic [4:0][63:0]  sm;
    logic [4:0][63:0]  mg;
    logic [4:0]        ng;
  } tl_t;

  function automatic logic [31:0] sext(input logic [31:0] p);
    logic signed [31:0] t;
    t = $signed(p << SextSh);
    return 32'(t >>> SextSh);
  endfunction

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return p;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Round half away from zero by 30 bits on the magnitude, then clamp.
  function automatic logic [63:0] rnd30(input logic [63:0] m, input logic [63:0] lim);
    logic [63:0] r;
    r = (m + (64'd1 << (UnitFrac - 1))) >> UnitFrac;
    return (r > lim) ? lim : r;
  endfunction

  function automatic logic [31:0] sgn32(input logic [63:0] m, input logic neg);
    return neg ? -m[31:0] : m[31:0];
  endfunction

  logic en;
  logic ld_ready;

  // Front stages: sign-extend, then difference target - eye.
  logic [1:0]       fv_q;
  vec3_t            e0_q, t0_q, u0_q, e1_q, u1_q;
  logic [2:0][32:0] d1_q;
  logic [2:0]       dneg;
  logic [2:0][32:0] dmag;

  // z normalizer
  logic             zv;
  vec3_t            za;
  logic             zdeg;
  logic [191:0]     zside;
  vec3_t            zs_eye, zs_up;

  // Cross product up x z.
  logic [1:0]       cv_q;
  logic [5:0][63:0] cp_q;
  logic [2:0][63:0] c_q;
  vec3_t            ce1_q, cz1_q, ce2_q, cz2_q;
  logic             cd1_q, cd2_q;
  logic [2:0]       cneg;
  logic [2:0][62:0] cmag;
  logic [2:0][63:0] cabs;

  // x normalizer
  logic             xv;
  vec3_t            xa;
  logic             xdeg;
  logic [192:0]     xside;
  vec3_t            xs_eye, xs_za;
  logic             xs_zdeg;

  // Tail: y axis, offsets.
  logic [NTail:1]   tv_q;
  tl_t              tl_q [NTail+1];
  tl_t              tl_d [NTail+1];

  // Advance everything unless the tail holds a basis the serializer refuses.
  assign en           = !tv_q[NTail] || ld_ready;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      cv_q <= '0;
      tv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[0], item_i.valid};
      cv_q <= {cv_q[0], zv};
      tv_q <= {tv_q[NTail-1:1], xv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q <= {sext(item_i.data.eye_z), sext(item_i.data.eye_y), sext(item_i.data.eye_x)};
      t0_q <= {sext(item_i.data.target_z), sext(item_i.data.target_y),
               sext(item_i.data.target_x)};
      u0_q <= {sext(item_i.data.up_z), sext(item_i.data.up_y), sext(item_i.data.up_x)};
      e1_q <= e0_q;
      u1_q <= u0_q;
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= 33'($signed(t0_q[i])) - 33'($signed(e0_q[i]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg[i] = d1_q[i][32];
      dmag[i] = d1_q[i][32] ? -d1_q[i] : d1_q[i];
    end
  end

  lav_norm #(
    .MagWidth  (33),
    .SideWidth (192)
  ) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[1]),
    .neg_i   (dneg),
    .mag_i   (dmag),
    .side_i  ({e1_q, u1_q}),
    .valid_o (zv),
    .unit_o  (za),
    .zero_o  (zdeg),
    .side_o  (zside)
  );

  assign {zs_eye, zs_up} = zside;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q[0] <= mul32(zs_up[1], za[2]);
      cp_q[1] <= mul32(zs_up[2], za[1]);
      cp_q[2] <= mul32(zs_up[2], za[0]);
      cp_q[3] <= mul32(zs_up[0], za[2]);
      cp_q[4] <= mul32(zs_up[0], za[1]);
      cp_q[5] <= mul32(zs_up[1], za[0]);
      ce1_q   <= zs_eye;
      cz1_q   <= za;
      cd1_q   <= zdeg;
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= cp_q[2*i] - cp_q[2*i+1];
      end
      ce2_q <= ce1_q;
      cz2_q <= cz1_q;
      cd2_q <= cd1_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = abs64(c_q[i]);
      cneg[i] = c_q[i][63];
      cmag[i] = cabs[i][62:0];
    end
  end

  lav_norm #(
    .MagWidth  (63),
    .SideWidth (193)
  ) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv_q[1]),
    .neg_i   (cneg),
    .mag_i   (cmag),
    .side_i  ({ce2_q, cz2_q, cd2_q}),
    .valid_o (xv),
    .unit_o  (xa),
    .zero_o  (xdeg),
    .side_o  (xside)
  );

  assign {xs_eye, xs_za, xs_zdeg} = xside;

  // Tail stages: products, sums, magnitude, round and clamp, sign; then the
  // y offset goes through the same steps once the y axis is known.
  always_comb begin
    tl_d[0]     = '0;
    tl_d[1]     = '0;
    tl_d[1].eye = xs_eye;
    tl_d[1].xa  = xa;
    tl_d[1].za  = xs_za;
    tl_d[1].deg = xs_zdeg | xdeg;
    tl_d[1].pr[0] = mul32(xs_za[1], xa[2]);
    tl_d[1].pr[1] = mul32(xs_za[2], xa[1]);
    tl_d[1].pr[2] = mul32(xs_za[2], xa[0]);
    tl_d[1].pr[3] = mul32(xs_za[0], xa[2]);
    tl_d[1].pr[4] = mul32(xs_za[0], xa[1]);
    tl_d[1].pr[5] = mul32(xs_za[1], xa[0]);
    for (int i = 0; i < 3; i++) begin
      tl_d[1].pr[6+i] = mul32(xa[i], xs_eye[i]);
      tl_d[1].pr[9+i] = mul32(xs_za[i], xs_eye[i]);
    end

    for (int t = 2; t <= NTail; t++) tl_d[t] = tl_q[t-1];

    for (int i = 0; i < 3; i++) begin
      tl_d[2].sm[i] = tl_q[1].pr[2*i] - tl_q[1].pr[2*i+1];
    end
    tl_d[2].sm[3] = tl_q[1].pr[6] + tl_q[1].pr[7] + tl_q[1].pr[8];
    tl_d[2].sm[4] = tl_q[1].pr[9] + tl_q[1].pr[10] + tl_q[1].pr[11];

    // Offsets negate the dot product: flip the result sign.
    for (int i = 0; i < 5; i++) begin
      tl_d[3].mg[i] = abs64(tl_q[2].sm[i]);
      tl_d[3].ng[i] = tl_q[2].sm[i][63] ^ (i >= 3);
    end

    for (int i = 0; i < 3; i++) begin
      tl_d[4].mg[i] = rnd30(tl_q[3].mg[i], LimUnit);
    end
    for (int i = 3; i < 5; i++) begin
      tl_d[4].mg[i] = rnd30(tl_q[3].mg[i], tl_q[3].ng[i] ? LimNeg : LimPos);
    end

    for (int i = 0; i < 3; i++) begin
      tl_d[5].ya[i] = sgn32(tl_q[4].mg[i], tl_q[4].ng[i]);
    end
    tl_d[5].off[0] = sgn32(tl_q[4].mg[3], tl_q[4].ng[3]);
    tl_d[5].off[2] = sgn32(tl_q[4].mg[4], tl_q[4].ng[4]);

    for (int i = 0; i < 3; i++) begin
      tl_d[6].pr[i] = mul32(tl_q[5].ya[i], tl_q[5].eye[i]);
    end
    tl_d[7].sm[0] = tl_q[6].pr[0] + tl_q[6].pr[1] + tl_q[6].pr[2];
    tl_d[8].mg[0] = abs64(tl_q[7].sm[0]);
    tl_d[8].ng[0] = ~tl_q[7].sm[0][63];
    tl_d[9].mg[0] = rnd30(tl_q[8].mg[0], tl_q[8].ng[0] ? LimNeg : LimPos);
    tl_d[10].off[1] = sgn32(tl_q[9].mg[0], tl_q[9].ng[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int t = 0; t <= NTail; t++) tl_q[t] <= tl_d[t];
    end
  end

  lav_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tv_q[NTail]),
    .ready_o (ld_ready),
    .xa_i    (tl_q[NTail].xa),
    .ya_i    (tl_q[NTail].ya),
    .za_i    (tl_q[NTail].za),
    .off_i   (tl_q[NTail].off),
    .deg_i   (tl_q[NTail].deg),
    .row_o   (row_o)
  );

endmodule

FILE: bench/look_at_view_matrix_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit_tb
// Self-checking bench for the fixed-point look-at view basis unit.
// ----------------------------------------------------------------------------
// A directed pose table comes first: the canonical camera, eye on target,
// zero up vector, up along the view line, and the coordinate extremes that
// drive the translation into saturation. Random poses follow, mostly small
// coordinates, with full-range, eye-on-target and parallel-up poses mixed in.
// A local basis model predicts the three rows of each accepted pose that has no
// typed rows; the row monitor checks each transfer against the oldest one.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit_tb;
  import lav_pkg::*;

  localparam int  CoordW      = CoordWidthDef;
  localparam int  RandomPoses = 160;
  localparam int  CalmFrom    = 130;   // no idling from this random pose on
  localparam int  HoldAt      = 60;    // sender drains the pipe here
  localparam int  StuckLimit  = 4000;
  localparam int  TailCycles  = 400;
  localparam longint UnitOne  = 64'sd1 << UnitFrac;

  typedef struct {
    in_item_t  pose;
    bit        typed;
    out_item_t rows [3];
  } pose_entry_t;

  logic clk_i;
  logic rst_ni;

  lav_in_if  item_if ();
  lav_out_if row_if ();

  look_at_view_matrix_unit #(.COORD_WIDTH(CoordW)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if.sink),
    .row_o  (row_if.source)
  );

  out_item_t   rows_due [$];
  pose_entry_t pose_table [$];
  int unsigned error_count = 0;
  int unsigned stuck_cycles = 0;
  bit          calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Basis model
  // --------------------------------------------------------------------------
  function automatic longint coord_of(logic [31:0] raw);
    longint v;
    v = longint'({{32{1'b0}}, raw});
    return (v <<< (64 - CoordW)) >>> (64 - CoordW);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Reduce by sh bits, rounding half away from zero.
  function automatic longint round_down(longint v, int sh);
    longint unsigned m;
    m = (magnitude(v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale v to unit length in Q1.30; returns 0 on zero length.
  function automatic bit unit_vector(input longint v [3], output longint u [3]);
    longint unsigned a [3];
    longint unsigned m, sum, len, q;
    int bits;
    m = 0;
    sum = 0;
    bits = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magnitude(v[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b0;
    end
    while (bits < 64 && (m >> bits) != 0) bits++;
    for (int i = 0; i < 3; i++) begin
      if (bits > 30) a[i] = a[i] >> (bits - 30);
      else if (bits < 30) a[i] = a[i] << (30 - bits);
      sum = sum + a[i] * a[i];
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint view_offset(longint ax [3], longint eye [3]);
    longint r, hi, lo;
    r = round_down(-(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]), UnitFrac);
    hi = (64'sd1 <<< (CoordW - 1)) - 1;
    lo = -(64'sd1 <<< (CoordW - 1));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  task automatic predict_basis(in_item_t p);
    longint eye [3], tgt [3], up [3], d [3], c [3];
    longint xa [3], ya [3], za [3], ax [3];
    bit     fine;
    out_item_t r;
    eye[0] = coord_of(p.eye_x);    eye[1] = coord_of(p.eye_y);    eye[2] = coord_of(p.eye_z);
    tgt[0] = coord_of(p.target_x); tgt[1] = coord_of(p.target_y); tgt[2] = coord_of(p.target_z);
    up[0]  = coord_of(p.up_x);     up[1]  = coord_of(p.up_y);     up[2]  = coord_of(p.up_z);
    for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
    fine = unit_vector(d, za);
    c[0] = up[1] * za[2] - up[2] * za[1];
    c[1] = up[2] * za[0] - up[0] * za[2];
    c[2] = up[0] * za[1] - up[1] * za[0];
    if (!unit_vector(c, xa)) fine = 1'b0;
    c[0] = za[1] * xa[2] - za[2] * xa[1];
    c[1] = za[2] * xa[0] - za[0] * xa[2];
    c[2] = za[0] * xa[1] - za[1] * xa[0];
    for (int i = 0; i < 3; i++) begin
      ya[i] = round_down(c[i], UnitFrac);
      if (ya[i] > UnitOne) ya[i] = UnitOne;
      if (ya[i] < -UnitOne) ya[i] = -UnitOne;
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) ax[i] = xa[i];
        else if (k == 1) ax[i] = ya[i];
        else ax[i] = za[i];
      end
      r.axis_x     = ax[0][31:0];
      r.axis_y     = ax[1][31:0];
      r.axis_z     = ax[2][31:0];
      r.offset     = 32'(view_offset(ax, eye));
      r.row        = (k == 0) ? RowX : (k == 1) ? RowY : RowZ;
      r.last       = (k == 2);
      r.degenerate = !fine;
      rows_due.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic out_item_t basis_row(int ax, int ay, int az, int off,
                                          logic [1:0] rw, bit degen);
    out_item_t r;
    r.axis_x = ax; r.axis_y = ay; r.axis_z = az; r.offset = off;
    r.row = rw; r.last = (rw == RowZ); r.degenerate = degen;
    return r;
  endfunction

  function automatic in_item_t make_pose(int ex, int ey, int ez, int tx, int ty,
                                         int tz, int ux, int uy, int uz);
    in_item_t p;
    p.eye_x = ex; p.eye_y = ey; p.eye_z = ez;
    p.target_x = tx; p.target_y = ty; p.target_z = tz;
    p.up_x = ux; p.up_y = uy; p.up_z = uz;
    return p;
  endfunction

  task automatic add_pose(in_item_t p, bit typed = 1'b0, out_item_t r0 = '0,
                          out_item_t r1 = '0, out_item_t r2 = '0);
    pose_entry_t e;
    e.pose = p; e.typed = typed;
    e.rows[0] = r0; e.rows[1] = r1; e.rows[2] = r2;
    pose_table.push_back(e);
  endtask

  function automatic int small_coord();
    return int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
  endfunction

  function automatic in_item_t random_pose();
    in_item_t p;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else begin
      p = make_pose(small_coord(), small_coord(), small_coord(), small_coord(),
                    small_coord(), small_coord(), small_coord(), small_coord(),
                    small_coord());
      if (kind == 8) begin
        // eye on target
        p.target_x = p.eye_x; p.target_y = p.eye_y; p.target_z = p.eye_z;
      end else if (kind == 9) begin
        // up along the view line
        p.up_x = p.target_x - p.eye_x;
        p.up_y = p.target_y - p.eye_y;
        p.up_z = p.target_z - p.eye_z;
      end
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Pose sender
  // --------------------------------------------------------------------------
  task automatic send_pose(pose_entry_t e);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= e.pose;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    // transfer taken at this edge
    if (e.typed) begin
      for (int k = 0; k < 3; k++) rows_due.push_back(e.rows[k]);
    end else begin
      predict_basis(e.pose);
    end
  endtask

  initial begin
    pose_entry_t e;
    int one;
    one = 32'sh0001_0000;
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    row_if.ready  = 1'b0;

    // canonical camera: looking down +z with +y up
    add_pose(make_pose(0, 0, 0, 0, 0, one, 0, one, 0), 1'b1,
             basis_row(32'sh4000_0000, 0, 0, 0, RowX, 1'b0),
             basis_row(0, 32'sh4000_0000, 0, 0, RowY, 1'b0),
             basis_row(0, 0, 32'sh4000_0000, 0, RowZ, 1'b0));
    // eye on target: everything zero
    add_pose(make_pose(one, -one, 5, one, -one, 5, 0, one, 0), 1'b1,
             basis_row(0, 0, 0, 0, RowX, 1'b1), basis_row(0, 0, 0, 0, RowY, 1'b1),
             basis_row(0, 0, 0, 0, RowZ, 1'b1));
    // all fields zero
    add_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
             basis_row(0, 0, 0, 0, RowX, 1'b1), basis_row(0, 0, 0, 0, RowY, 1'b1),
             basis_row(0, 0, 0, 0, RowZ, 1'b1));
    // zero up vector, up along the view line
    add_pose(make_pose(0, 0, 0, 0, 0, one, 0, 0, 0), 1'b1,
             basis_row(0, 0, 0, 0, RowX, 1'b1), basis_row(0, 0, 0, 0, RowY, 1'b1),
             basis_row(0, 0, 32'sh4000_0000, 0, RowZ, 1'b1));
    add_pose(make_pose(one, 2 * one, 3, 4 * one, -one, 7, 6 * one, -6 * one, 8));
    // extremes; the offsets saturate
    add_pose(make_pose(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                       32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 32'sh8000_0000));
    add_pose(make_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0));
    add_pose(make_pose(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                       32'sh7fff_ffff, 32'sh7fff_ffff, 1, -1, 1));
    add_pose(make_pose(-1, -1, -1, 1, 1, 1, -1, 1, -1));
    add_pose(make_pose(0, 0, 32'sh7fff_ffff, 0, 0, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    add_pose(make_pose(32'sh7fff_ffff, 0, 0, 32'sh7fff_fffe, 1, 0, 0, 0, one));
    add_pose(make_pose(3 * one, 0, -2 * one, -one, one, one, 0, -one, 0));
    add_pose(make_pose(0, one, 0, 0, 2 * one, 0, one, 0, 0));
    add_pose(make_pose(12345, -67890, 424242, -99, 7 * one, 3, one, one, -one));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pose_table[i]) send_pose(pose_table[i]);

    for (int n = 0; n < RandomPoses; n++) begin
      if (n == HoldAt) begin
        // drain the pipe before sending on
        item_if.valid <= 1'b0;
        @(posedge clk_i);
        while (rows_due.size() != 0) @(posedge clk_i);
      end
      if (n == CalmFrom) calm = 1'b1;
      e.pose = random_pose();
      e.typed = 1'b0;
      send_pose(e);
    end
    item_if.valid <= 1'b0;

    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("look_at_view_matrix_unit_tb: done, clean");
    end else begin
      $display("look_at_view_matrix_unit_tb: done, errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Row monitor and receiver stalls
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni && row_if.valid && row_if.ready) begin
      got = row_if.data;
      if (rows_due.size() == 0) begin
        $error("row transfer with nothing expected: row %0d", got.row);
        error_count++;
      end else begin
        want = rows_due.pop_front();
        if (got.axis_x !== want.axis_x) begin
          $error("axis_x: expected %0d, got %0d", want.axis_x, got.axis_x);
          error_count++;
        end
        if (got.axis_y !== want.axis_y) begin
          $error("axis_y: expected %0d, got %0d", want.axis_y, got.axis_y);
          error_count++;
        end
        if (got.axis_z !== want.axis_z) begin
          $error("axis_z: expected %0d, got %0d", want.axis_z, got.axis_z);
          error_count++;
        end
        if (got.offset !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, got.offset);
          error_count++;
        end
        if (got.row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, got.row);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          error_count++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, got.degenerate);
          error_count++;
        end
      end
    end
    // stall the receiver in random bursts, none in the calm tail
    if (stall_left > 0) begin
      stall_left--;
      row_if.ready <= (stall_left == 0);
    end else if (rst_ni && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9);
      row_if.ready <= 1'b0;
    end else begin
      row_if.ready <= rst_ni;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (row_if.valid && row_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("look_at_view_matrix_unit_tb: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
